>>> design/lpgf_pkg.sv
`default_nettype none

package lpgf_pkg;

    // Field and internal widths
    localparam int SENSOR_COUNT = 5;
    localparam int MID_SENSOR   = SENSOR_COUNT / 2;
    localparam int RATE_W       = 16;
    localparam int STEER_W      = 14;
    localparam int LOFFS_W      = 10;
    localparam int OFFSET_W     = 19;
    localparam int HEAD_W       = 24;
    localparam int ERR_W        = 24;
    localparam int MUL_A_W      = 27;
    localparam int MUL_B_W      = 18;
    localparam int PROD_W       = 45;
    localparam int WIDE_W       = 48;
    localparam int WEIGHT_W     = 17;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 17;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

    localparam logic signed [WIDE_W-1:0] STEER_MAX = 48'sd7680;
    localparam logic signed [WIDE_W-1:0] LOFFS_MAX = 48'sd384;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_SCALE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT   = 3'd5;

    // Register reset values
    localparam logic [16:0] RST_BLEND_WEIGHT  = 17'd45875;
    localparam logic [6:0]  RST_ERROR_SCALE   = 7'd10;
    localparam logic [16:0] RST_SMOOTH_WEIGHT = 17'd32768;
    localparam logic [15:0] RST_STEP_TIME     = 16'd197;
    localparam logic [14:0] RST_HEADING_LIMIT = 15'd2560;
    localparam logic [14:0] RST_ERROR_LIMIT   = 15'd7680;

    typedef struct packed {
        logic [16:0] blend_weight;
        logic [6:0]  error_scale;
        logic [16:0] smooth_weight;
        logic [15:0] step_time;
        logic [14:0] heading_limit;
        logic [14:0] error_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        A_RATE_SUM,
        A_OFFSET,
        A_HEAD,
        A_PROD,
        A_X,
        A_FILT
    } t_a_sel;

    typedef enum logic [2:0] {
        B_STEP,
        B_W,
        B_WC,
        B_ES,
        B_S,
        B_SC
    } t_b_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        HEAD_HOLD,
        HEAD_INTEG,
        HEAD_BLEND
    } t_head_op;

    typedef struct packed {
        logic     take;
        logic     mul_en;
        t_a_sel   a_sel;
        t_b_sel   b_sel;
        t_acc_op  acc_op;
        t_head_op head_op;
        logic     x_load;
        logic     filt_load;
        logic     out_load;
    } t_cmd;

    // Round to nearest, ties away from zero, then shift right
    function automatic logic signed [WIDE_W-1:0] round_shift(
        input logic signed [WIDE_W-1:0] v,
        input int unsigned              sh
    );
        logic signed [WIDE_W-1:0] half;
        half = 48'sd1 <<< (sh - 1);
        if (v < 0) begin
            round_shift = (v + half - 48'sd1) >>> sh;
        end else begin
            round_shift = (v + half) >>> sh;
        end
    endfunction

    function automatic logic signed [WIDE_W-1:0] clamp_sym(
        input logic signed [WIDE_W-1:0] v,
        input logic signed [WIDE_W-1:0] lim
    );
        if (v > lim) begin
            clamp_sym = lim;
        end else if (v < -lim) begin
            clamp_sym = -lim;
        end else begin
            clamp_sym = v;
        end
    endfunction

    // Gain-scaled rounded mean of lit sensor positions, signed Q2.16.
    // Positions: -1.5, -0.3, 0, 0.3, 1.5; edge patterns carry gain 10 or 4.
    function automatic logic signed [OFFSET_W-1:0] line_offset_of(
        input logic [SENSOR_COUNT-1:0] bits
    );
        case (bits)
            5'd0:    line_offset_of = 19'sd0;
            5'd1:    line_offset_of = -19'sd98304;
            5'd2:    line_offset_of = -19'sd19661;
            5'd3:    line_offset_of = -19'sd58983;
            5'd4:    line_offset_of = 19'sd0;
            5'd5:    line_offset_of = -19'sd49152;
            5'd6:    line_offset_of = -19'sd9831;
            5'd7:    line_offset_of = -19'sd157288;
            5'd8:    line_offset_of = 19'sd19661;
            5'd9:    line_offset_of = -19'sd39322;
            5'd10:   line_offset_of = 19'sd0;
            5'd11:   line_offset_of = -19'sd32768;
            5'd12:   line_offset_of = 19'sd9831;
            5'd13:   line_offset_of = -19'sd26214;
            5'd14:   line_offset_of = 19'sd0;
            5'd15:   line_offset_of = -19'sd245760;
            5'd16:   line_offset_of = 19'sd98304;
            5'd17:   line_offset_of = 19'sd0;
            5'd18:   line_offset_of = 19'sd39322;
            5'd19:   line_offset_of = -19'sd6554;
            5'd20:   line_offset_of = 19'sd49152;
            5'd21:   line_offset_of = 19'sd0;
            5'd22:   line_offset_of = 19'sd26214;
            5'd23:   line_offset_of = -19'sd4915;
            5'd24:   line_offset_of = 19'sd58983;
            5'd25:   line_offset_of = 19'sd6554;
            5'd26:   line_offset_of = 19'sd32768;
            5'd27:   line_offset_of = 19'sd0;
            5'd28:   line_offset_of = 19'sd157288;
            5'd29:   line_offset_of = 19'sd4915;
            5'd30:   line_offset_of = 19'sd245760;
            5'd31:   line_offset_of = 19'sd0;
            default: line_offset_of = 19'sd0;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> design/lpgf_in_if.sv
`default_nettype none

interface lpgf_in_if;
    import lpgf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [SENSOR_COUNT-1:0]   line_bits;
    logic signed [RATE_W-1:0]  turn_rate;

    modport source (output valid, output line_bits, output turn_rate, input ready);
    modport sink   (input valid, input line_bits, input turn_rate, output ready);
endinterface

`default_nettype wire

>>> design/lpgf_out_if.sv
`default_nettype none

interface lpgf_out_if;
    import lpgf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [STEER_W-1:0] steer_error;
    logic signed [LOFFS_W-1:0] line_offset;

    modport source (output valid, output steer_error, output line_offset, input ready);
    modport sink   (input valid, input steer_error, input line_offset, output ready);
endinterface

`default_nettype wire

>>> design/lpgf_cfg_if.sv
`default_nettype none

interface lpgf_cfg_if;
    import lpgf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/lpgf_dp.sv
`default_nettype none

module lpgf_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  lpgf_pkg::t_cmd                          i_cmd,
    input  lpgf_pkg::t_cfg                          i_cfg,
    input  logic [lpgf_pkg::SENSOR_COUNT-1:0]       i_line_bits,
    input  logic signed [lpgf_pkg::RATE_W-1:0]      i_turn_rate,
    output logic signed [lpgf_pkg::STEER_W-1:0]     o_steer_error,
    output logic signed [lpgf_pkg::LOFFS_W-1:0]     o_line_offset
);
    import lpgf_pkg::*;

    logic signed [RATE_W-1:0]   r_rate;
    logic signed [RATE_W-1:0]   r_prev_rate;
    logic signed [OFFSET_W-1:0] r_offset;
    logic                       r_active;
    logic signed [HEAD_W-1:0]   r_head;
    logic signed [ERR_W-1:0]    r_filt;
    logic signed [ERR_W-1:0]    r_x;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   r_acc;
    logic signed [STEER_W-1:0]  r_steer;
    logic signed [LOFFS_W-1:0]  r_loffs;

    logic [WEIGHT_W-1:0]        w_sat, w_cmp, s_sat, s_cmp;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_full;
    logic signed [OFFSET_W-1:0] offs_in;
    logic signed [WIDE_W-1:0]   head_lim, err_lim;
    logic signed [WIDE_W-1:0]   head_integ, acc_rnd, x_next, steer_next, loffs_next;

    // Weights above one act as one
    assign w_sat = (i_cfg.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_cfg.blend_weight;
    assign w_cmp = WEIGHT_ONE - w_sat;
    assign s_sat = (i_cfg.smooth_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_cfg.smooth_weight;
    assign s_cmp = WEIGHT_ONE - s_sat;

    assign head_lim = {25'd0, i_cfg.heading_limit, 8'd0};
    assign err_lim  = {25'd0, i_cfg.error_limit, 8'd0};

    always_comb begin
        case (i_cmd.a_sel)
            A_RATE_SUM: mul_a = MUL_A_W'(r_prev_rate) + MUL_A_W'(r_rate);
            A_OFFSET:   mul_a = MUL_A_W'(r_offset);
            A_HEAD:     mul_a = MUL_A_W'(r_head);
            A_PROD:     mul_a = r_prod[MUL_A_W-1:0];
            A_X:        mul_a = MUL_A_W'(r_x);
            A_FILT:     mul_a = MUL_A_W'(r_filt);
            default:    mul_a = '0;
        endcase
        case (i_cmd.b_sel)
            B_STEP:  mul_b = MUL_B_W'(i_cfg.step_time);
            B_W:     mul_b = MUL_B_W'(w_sat);
            B_WC:    mul_b = MUL_B_W'(w_cmp);
            B_ES:    mul_b = MUL_B_W'(i_cfg.error_scale);
            B_S:     mul_b = MUL_B_W'(s_sat);
            B_SC:    mul_b = MUL_B_W'(s_cmp);
            default: mul_b = '0;
        endcase
    end

    // Signed 27x18 product, sign-extended to the accumulator width
    assign mul_full = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign offs_in    = line_offset_of(i_line_bits);
    assign head_integ = clamp_sym(WIDE_W'(r_head) + round_shift(WIDE_W'(r_prod), 9), head_lim);
    assign acc_rnd    = round_shift(WIDE_W'(r_acc), 16);
    assign x_next     = clamp_sym(r_active ? acc_rnd : WIDE_W'(r_filt), err_lim);
    assign steer_next = clamp_sym(round_shift(WIDE_W'(r_filt), 8), STEER_MAX);
    assign loffs_next = clamp_sym(round_shift(WIDE_W'(r_offset), 8), LOFFS_MAX);

    // Filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_prev_rate <= '0;
            r_filt      <= '0;
        end else begin
            case (i_cmd.head_op)
                HEAD_INTEG: r_head <= head_integ[HEAD_W-1:0];
                HEAD_BLEND: if (r_active) begin
                    r_head <= acc_rnd[HEAD_W-1:0];
                end
                default: ;
            endcase
            if (i_cmd.filt_load) begin
                r_filt      <= acc_rnd[ERR_W-1:0];
                r_prev_rate <= r_rate;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_rate   <= i_turn_rate;
            r_offset <= offs_in;
            r_active <= (offs_in != '0) || i_line_bits[MID_SENSOR];
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_full;
        end
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            default:  ;
        endcase
        if (i_cmd.x_load) begin
            r_x <= x_next[ERR_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_steer <= steer_next[STEER_W-1:0];
            r_loffs <= loffs_next[LOFFS_W-1:0];
        end
    end

    assign o_steer_error = r_steer;
    assign o_line_offset = r_loffs;

endmodule

`default_nettype wire

>>> design/lpgf_ctrl.sv
`default_nettype none

module lpgf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output lpgf_pkg::t_cmd o_cmd
);
    import lpgf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_PUT
    } t_state;

    localparam logic [3:0] LAST_STEP = 4'd10;

    t_state     r_state;
    logic [3:0] r_step;
    logic       r_out_valid;
    logic       accept;
    logic       slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Step schedule: multiply in one step, consume the product in the next
    always_comb begin
        o_cmd          = '0;
        o_cmd.a_sel    = A_RATE_SUM;
        o_cmd.b_sel    = B_STEP;
        o_cmd.acc_op   = ACC_HOLD;
        o_cmd.head_op  = HEAD_HOLD;
        o_cmd.take     = accept;
        o_cmd.out_load = (r_state == S_PUT) && slot_free;
        if (r_state == S_RUN) begin
            case (r_step)
                4'd0: begin
                    o_cmd.mul_en = 1'b1;
                end
                4'd1: begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.a_sel   = A_OFFSET;
                    o_cmd.b_sel   = B_W;
                    o_cmd.head_op = HEAD_INTEG;
                end
                4'd2: begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.a_sel  = A_HEAD;
                    o_cmd.b_sel  = B_WC;
                    o_cmd.acc_op = ACC_LOAD;
                end
                4'd3: begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.a_sel  = A_OFFSET;
                    o_cmd.b_sel  = B_ES;
                    o_cmd.acc_op = ACC_ADD;
                end
                4'd4: begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.a_sel   = A_PROD;
                    o_cmd.b_sel   = B_W;
                    o_cmd.head_op = HEAD_BLEND;
                end
                4'd5: begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.a_sel  = A_HEAD;
                    o_cmd.b_sel  = B_WC;
                    o_cmd.acc_op = ACC_LOAD;
                end
                4'd6: begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.a_sel  = A_FILT;
                    o_cmd.b_sel  = B_SC;
                    o_cmd.acc_op = ACC_ADD;
                end
                4'd7: begin
                    o_cmd.x_load = 1'b1;
                    o_cmd.acc_op = ACC_LOAD;
                end
                4'd8: begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.a_sel  = A_X;
                    o_cmd.b_sel  = B_S;
                end
                4'd9: begin
                    o_cmd.acc_op = ACC_ADD;
                end
                4'd10: begin
                    o_cmd.filt_load = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (accept) begin
                    r_state <= S_RUN;
                    r_step  <= '0;
                end
                S_RUN: if (r_step == LAST_STEP) begin
                    r_state <= S_PUT;
                end else begin
                    r_step <= r_step + 4'd1;
                end
                S_PUT: if (slot_free) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RUN) && (r_step == '0))
        else $error("accepted beat did not start the step sequence");

    a_run_ends_in_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_step == LAST_STEP) |=> (r_state == S_PUT))
        else $error("step sequence did not hand over to output");

    a_load_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("waiting result dropped");

endmodule

`default_nettype wire

>>> design/line_position_gyro_fusion.sv
// A beat accepted while idle runs through 11 steps of the shared 27x18 multiplier and
// accumulator, then the output write. No new beat is taken until that write; a result
// left untaken holds the block in its output step.
// Reset (i_rst_n, synchronous, active low): registers to defaults, filter state zero.
`default_nettype none

module line_position_gyro_fusion (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lpgf_in_if.sink       i_in,
    lpgf_out_if.source    o_out,
    lpgf_cfg_if.sink      i_cfg
);
    import lpgf_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;

    // Configuration writes are always taken; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blend_weight  <= RST_BLEND_WEIGHT;
            r_cfg.error_scale   <= RST_ERROR_SCALE;
            r_cfg.smooth_weight <= RST_SMOOTH_WEIGHT;
            r_cfg.step_time     <= RST_STEP_TIME;
            r_cfg.heading_limit <= RST_HEADING_LIMIT;
            r_cfg.error_limit   <= RST_ERROR_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BLEND_WEIGHT:  r_cfg.blend_weight  <= i_cfg.data[16:0];
                REG_ERROR_SCALE:   r_cfg.error_scale   <= i_cfg.data[6:0];
                REG_SMOOTH_WEIGHT: r_cfg.smooth_weight <= i_cfg.data[16:0];
                REG_STEP_TIME:     r_cfg.step_time     <= i_cfg.data[15:0];
                REG_HEADING_LIMIT: r_cfg.heading_limit <= i_cfg.data[14:0];
                REG_ERROR_LIMIT:   r_cfg.error_limit   <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    // Sequencer: walks the multiply schedule and owns the handshakes
    lpgf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // Datapath: offset table, heading integrator, blend and low-pass filter
    lpgf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (r_cfg),
        .i_line_bits   (i_in.line_bits),
        .i_turn_rate   (i_in.turn_rate),
        .o_steer_error (o_out.steer_error),
        .o_line_offset (o_out.line_offset)
    );

endmodule

`default_nettype wire

>>> dv/line_position_gyro_fusion_checker.sv
`timescale 1ns / 1ps

module line_position_gyro_fusion_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lpgf_in_if   i_in_mon,
    lpgf_out_if  i_out_mon,
    lpgf_cfg_if  i_cfg_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import lpgf_pkg::*;

    localparam longint ONE_Q16 = 65536;

    // Edge patterns that carry an extra gain on the offset
    localparam logic [SENSOR_COUNT-1:0] EDGE_LEFT_WIDE    = 5'b01111;
    localparam logic [SENSOR_COUNT-1:0] EDGE_RIGHT_WIDE   = 5'b11110;
    localparam logic [SENSOR_COUNT-1:0] EDGE_LEFT_NARROW  = 5'b00111;
    localparam logic [SENSOR_COUNT-1:0] EDGE_RIGHT_NARROW = 5'b11100;
    localparam longint GAIN_WIDE   = 10;
    localparam longint GAIN_NARROW = 4;

    typedef struct packed {
        logic signed [STEER_W-1:0] steer_error;
        logic signed [LOFFS_W-1:0] line_offset;
    } t_steer_beat;

    t_cfg        regs;
    longint      heading_q16;
    longint      last_rate;
    longint      held_error_q16;
    t_steer_beat steer_due[$];

    // Round half away from zero, then drop sh fraction bits
    function automatic longint round_drop(input longint v, input int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp_mag(input longint v, input longint lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    function automatic longint weight_cap(input logic [WEIGHT_W-1:0] w);
        longint wl;
        wl = longint'(w);
        return (wl > ONE_Q16) ? ONE_Q16 : wl;
    endfunction

    // Sensor positions in Q16.16, far left to far right
    function automatic longint sensor_place(input int i);
        case (i)
            0:       return -98304;
            1:       return -19661;
            3:       return 19661;
            4:       return 98304;
            default: return 0;
        endcase
    endfunction

    function automatic longint offset_of_bits(input logic [SENSOR_COUNT-1:0] bits);
        longint sum;
        longint mag;
        longint lit;
        longint gain;
        sum = 0;
        lit = 0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (bits[i]) begin
                sum += sensor_place(i);
                lit++;
            end
        end
        if (lit == 0) begin
            return 0;
        end
        gain = 1;
        if (bits == EDGE_LEFT_WIDE || bits == EDGE_RIGHT_WIDE) begin
            gain = GAIN_WIDE;
        end else if (bits == EDGE_LEFT_NARROW || bits == EDGE_RIGHT_NARROW) begin
            gain = GAIN_NARROW;
        end
        mag = (sum < 0) ? -sum : sum;
        mag = (mag + lit / 2) / lit;
        return ((sum < 0) ? -mag : mag) * gain;
    endfunction

    // Advance the fusion state by one sample and queue the result it must give
    task automatic fuse_step(input logic [SENSOR_COUNT-1:0] bits,
                             input logic signed [RATE_W-1:0] rate);
        longint rate_q8;
        longint offset_q16;
        longint step;
        longint head_lim;
        longint err_lim;
        longint scale;
        longint w;
        longint s;
        longint raw;
        longint port;
        t_steer_beat beat;
        rate_q8    = longint'(rate);
        step       = longint'(regs.step_time);
        head_lim   = longint'(regs.heading_limit);
        err_lim    = longint'(regs.error_limit);
        scale      = longint'(regs.error_scale);
        offset_q16 = offset_of_bits(bits);

        heading_q16 += round_drop((last_rate + rate_q8) * step, 9);
        heading_q16 = clamp_mag(heading_q16, head_lim <<< 8);

        if (offset_q16 != 0 || bits[MID_SENSOR]) begin
            w = weight_cap(regs.blend_weight);
            heading_q16 = round_drop(heading_q16 * (ONE_Q16 - w) + offset_q16 * w, 16);
            raw = round_drop(heading_q16 * (ONE_Q16 - w) + offset_q16 * w * scale, 16);
        end else begin
            raw = held_error_q16;
        end
        last_rate = rate_q8;

        raw = clamp_mag(raw, err_lim <<< 8);
        s = weight_cap(regs.smooth_weight);
        held_error_q16 = round_drop(raw * s + held_error_q16 * (ONE_Q16 - s), 16);

        port = clamp_mag(round_drop(held_error_q16, 8), longint'(STEER_MAX));
        beat.steer_error = port[STEER_W-1:0];
        port = clamp_mag(round_drop(offset_q16, 8), longint'(LOFFS_MAX));
        beat.line_offset = port[LOFFS_W-1:0];
        steer_due.push_back(beat);
    endtask

    always @(posedge i_clk) begin : watch
        t_steer_beat due;
        if (!i_rst_n) begin
            regs.blend_weight  = RST_BLEND_WEIGHT;
            regs.error_scale   = RST_ERROR_SCALE;
            regs.smooth_weight = RST_SMOOTH_WEIGHT;
            regs.step_time     = RST_STEP_TIME;
            regs.heading_limit = RST_HEADING_LIMIT;
            regs.error_limit   = RST_ERROR_LIMIT;
            heading_q16    = 0;
            last_rate      = 0;
            held_error_q16 = 0;
            steer_due.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // Retire the result beat before taking a new sample on the same edge
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (steer_due.size() == 0) begin
                    $error("result beat with nothing expected: steer_error %0d, line_offset %0d",
                           i_out_mon.steer_error, i_out_mon.line_offset);
                    o_fail_count++;
                end else begin
                    due = steer_due.pop_front();
                    o_checked++;
                    if (due.steer_error !== i_out_mon.steer_error) begin
                        $error("steer_error: expected %0d, got %0d",
                               due.steer_error, i_out_mon.steer_error);
                        o_fail_count++;
                    end
                    if (due.line_offset !== i_out_mon.line_offset) begin
                        $error("line_offset: expected %0d, got %0d",
                               due.line_offset, i_out_mon.line_offset);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (i_cfg_mon.index)
                    REG_BLEND_WEIGHT:  regs.blend_weight  = i_cfg_mon.data[16:0];
                    REG_ERROR_SCALE:   regs.error_scale   = i_cfg_mon.data[6:0];
                    REG_SMOOTH_WEIGHT: regs.smooth_weight = i_cfg_mon.data[16:0];
                    REG_STEP_TIME:     regs.step_time     = i_cfg_mon.data[15:0];
                    REG_HEADING_LIMIT: regs.heading_limit = i_cfg_mon.data[14:0];
                    REG_ERROR_LIMIT:   regs.error_limit   = i_cfg_mon.data[14:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                fuse_step(i_in_mon.line_bits, i_in_mon.turn_rate);
            end
        end
        o_pending = steer_due.size();
    end

endmodule

>>> dv/line_position_gyro_fusion_tb.sv
`timescale 1ns / 1ps

module line_position_gyro_fusion_tb;
    import lpgf_pkg::*;

    // Register settings the run steps through, one per phase
    typedef enum int {
        PLAN_MAX,
        PLAN_ZERO,
        PLAN_MILD,
        PLAN_UNITY,
        PLAN_WIDE,
        PLAN_DEFAULT
    } t_reg_plan;

    // Index beyond the register map: the write must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

    localparam int PHASE_BEATS = 270;
    localparam int RATE_MAX    = 32767;
    localparam int RATE_MIN    = -32768;

    logic clk;
    logic rst_n;

    int fail_count;
    int pending;
    int checked;
    int sent;
    int settings_used;
    bit quiet;
    int rate_walk;
    int track_pos;

    lpgf_in_if  in_bus();
    lpgf_out_if out_bus();
    lpgf_cfg_if cfg_bus();

    line_position_gyro_fusion u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    line_position_gyro_fusion_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .i_cfg_mon    (cfg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Result side: stall in random bursts, with runs of full
    // acceptance in between; once the run goes quiet, never stall.
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                out_bus.ready = 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge clk);
            end else begin
                out_bus.ready = 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
        end
    end

    // Drop valid for a gap set by n and scramble the payload meanwhile
    task automatic gap_in(input int n);
        @(negedge clk);
        in_bus.valid     = 1'b0;
        in_bus.line_bits = SENSOR_COUNT'($urandom);
        in_bus.turn_rate = RATE_W'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    // Present one sample and hold it until the block takes the beat
    task automatic push_sample(input logic [SENSOR_COUNT-1:0] bits,
                               input logic signed [RATE_W-1:0] rate);
        @(negedge clk);
        in_bus.valid     = 1'b1;
        in_bus.line_bits = bits;
        in_bus.turn_rate = rate;
        do @(posedge clk); while (!in_bus.ready);
        sent++;
    endtask

    task automatic offer(input logic [SENSOR_COUNT-1:0] bits,
                         input logic signed [RATE_W-1:0] rate);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap_in($urandom_range(1, 10));
        end
        push_sample(bits, rate);
    endtask

    // Hold the sender until every queued result has been taken
    task automatic settle();
        gap_in(1);
        wait (pending == 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
        cfg_bus.data  = CFG_DATA_W'($urandom);
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] blend,
                             input logic [CFG_DATA_W-1:0] scale,
                             input logic [CFG_DATA_W-1:0] smooth,
                             input logic [CFG_DATA_W-1:0] step,
                             input logic [CFG_DATA_W-1:0] head_lim,
                             input logic [CFG_DATA_W-1:0] err_lim);
        write_reg(REG_BLEND_WEIGHT, blend);
        write_reg(REG_ERROR_SCALE, scale);
        write_reg(REG_SMOOTH_WEIGHT, smooth);
        write_reg(REG_STEP_TIME, step);
        write_reg(REG_HEADING_LIMIT, head_lim);
        write_reg(REG_ERROR_LIMIT, err_lim);
    endtask

    task automatic apply_plan(input t_reg_plan plan);
        case (plan)
            // Every field at its top: weights beyond one, heading saturates fast
            PLAN_MAX:     write_all(17'h1FFFF, 17'h7F, 17'h1FFFF, 17'hFFFF,
                                    17'h7FFF, 17'h7FFF);
            PLAN_ZERO:    write_all('0, '0, '0, '0, '0, '0);
            PLAN_MILD:    write_all(CFG_DATA_W'($urandom_range(0, 65536)),
                                    CFG_DATA_W'($urandom_range(0, 100)),
                                    CFG_DATA_W'($urandom_range(0, 65536)),
                                    CFG_DATA_W'($urandom_range(0, 2000)),
                                    CFG_DATA_W'($urandom_range(0, 4000)),
                                    CFG_DATA_W'($urandom_range(0, 10000)));
            PLAN_UNITY:   write_all(WEIGHT_ONE, 17'd1, WEIGHT_ONE, 17'd1000,
                                    17'd512, 17'd1024);
            // Raw 17-bit words: upper bits of the narrow registers are junk
            PLAN_WIDE: begin
                write_all(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
                write_reg(REG_SPARE, CFG_DATA_W'($urandom));
            end
            default:      write_all(CFG_DATA_W'(RST_BLEND_WEIGHT),
                                    CFG_DATA_W'(RST_ERROR_SCALE),
                                    CFG_DATA_W'(RST_SMOOTH_WEIGHT),
                                    CFG_DATA_W'(RST_STEP_TIME),
                                    CFG_DATA_W'(RST_HEADING_LIMIT),
                                    CFG_DATA_W'(RST_ERROR_LIMIT));
        endcase
        settings_used++;
    endtask

    // Mostly a robot following a line: the lit sensors drift one step at a
    // time, the turn rate wanders, now and then the line is lost or an edge
    // pattern appears. The rest is raw noise on both fields.
    task automatic run_phase(input t_reg_plan plan, input int beats);
        int k;
        int len;
        bit held;
        logic [SENSOR_COUNT-1:0] bits;
        k    = 0;
        held = 1'b0;
        settle();
        apply_plan(plan);
        while (k < beats) begin
            if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(5, 30);
                repeat (len) begin
                    track_pos += int'($urandom_range(0, 2)) - 1;
                    if (track_pos < 0) track_pos = 0;
                    if (track_pos > 8) track_pos = 8;
                    rate_walk += int'($urandom_range(0, 4000)) - 2000;
                    if ($urandom_range(0, 24) == 0) begin
                        rate_walk = $urandom_range(0, 1) ? RATE_MAX : RATE_MIN;
                    end
                    if (rate_walk > RATE_MAX) rate_walk = RATE_MAX;
                    if (rate_walk < RATE_MIN) rate_walk = RATE_MIN;
                    case ($urandom_range(0, 19))
                        0: bits = '0;
                        1: begin
                            case ($urandom_range(0, 3))
                                0:       bits = 5'b00111;
                                1:       bits = 5'b01111;
                                2:       bits = 5'b11100;
                                default: bits = 5'b11110;
                            endcase
                        end
                        // even positions light one sensor, odd ones a pair
                        default: bits = track_pos[0] ? (5'b00011 << (track_pos / 2))
                                                     : (5'b00001 << (track_pos / 2));
                    endcase
                    offer(bits, rate_walk[RATE_W-1:0]);
                    k++;
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    offer(SENSOR_COUNT'($urandom_range(0, 31)), RATE_W'($urandom));
                    k++;
                end
            end
            // Drain the pipe once in the middle of each mild-plan phase
            if (plan == PLAN_MILD && !held && k >= beats / 2) begin
                settle();
                held = 1'b1;
            end
        end
    endtask

    initial begin
        quiet         = 1'b0;
        sent          = 0;
        settings_used = 0;
        rate_walk     = 0;
        track_pos     = 4;
        rst_n            = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.line_bits = '0;
        in_bus.turn_rate = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = REG_BLEND_WEIGHT;
        cfg_bus.data     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats on the reset settings: every edge-gain pattern,
        // no line, middle sensor alone, symmetric patterns that cancel to
        // zero offset with and without the middle sensor, rate extremes.
        offer(5'b00000, 16'sd0);
        offer(5'b00100, 16'sd0);
        offer(5'b11110, 16'sd32767);
        offer(5'b01111, -16'sd32768);
        offer(5'b11100, 16'sd32767);
        offer(5'b00111, -16'sd32768);
        offer(5'b01010, 16'sd256);
        offer(5'b10001, -16'sd256);
        offer(5'b11111, 16'sd0);
        offer(5'b00001, 16'sd32767);
        offer(5'b10000, 16'sd32767);
        offer(5'b00010, -16'sd1);
        offer(5'b01000, 16'sd1);
        offer(5'b00011, 16'sd0);
        offer(5'b11000, 16'sd0);
        offer(5'b10101, -16'sd32768);
        offer(5'b11011, 16'sd100);
        offer(5'b00000, -16'sd32768);
        offer(5'b00000, 16'sd32767);
        offer(5'b01110, 16'sd0);
        offer(5'b10011, -16'sd5);

        run_phase(PLAN_MAX, PHASE_BEATS);
        run_phase(PLAN_ZERO, PHASE_BEATS);
        run_phase(PLAN_MILD, PHASE_BEATS);
        run_phase(PLAN_UNITY, PHASE_BEATS);
        run_phase(PLAN_WIDE, PHASE_BEATS);
        run_phase(PLAN_MILD, PHASE_BEATS);
        // Last stretch at full rate on both sides, back on the reset values
        quiet = 1'b1;
        run_phase(PLAN_DEFAULT, PHASE_BEATS);

        // Drain, then allow the block's latency for any stray beat
        settle();
        repeat (20) @(posedge clk);

        $display("run: %0d sensor/gyro samples over %0d register settings, edge, empty",
                 sent, settings_used + 1);
        $display("run: and saturating cases included; %0d result beats compared, %0d mismatches",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Give up well past the slowest legal run
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
